@@ rtl/mmlr_pkg.sv @@
// Shared types and constants for the mono-mix linear resampler.
package mmlr_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int STEP_W      = 20;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = 6;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE = 1'd1;

  localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;
  localparam logic [CNT_W-1:0]  CNT_LAST   = 6'(MAX_RESULTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_MUL,
    ST_SUM,
    ST_HOLD
  } state_t;

endpackage

@@ rtl/mono_mix_linear_resampler_core.sv @@
// Flow: a frame is accepted in ST_IDLE and mixed in ST_MIX; each result then passes ST_MUL,
// ST_SUM, then ST_HOLD until taken, using the shared multiplier and one-deep output register.
// A frame with no result returns to ST_IDLE after ST_MIX; no frame is taken during a run.
// Reset (rst, synchronous): history cleared, phase 2.0, step 1.0, mono mode, no word pending.
// Config writes are taken in any cycle; they are meant for idle periods only.
module mono_mix_linear_resampler_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [2*mmlr_pkg::SAMPLE_W-1:0]     s_tdata,   // first_sample, second_sample
  input  logic                                s_tuser,   // begin_stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mmlr_pkg::SAMPLE_W-1:0]       m_tdata,   // out_sample
  output logic                                m_tlast,   // last_of_run
  input  logic                                cfg_wr_en,
  input  logic [mmlr_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [mmlr_pkg::STEP_W-1:0]         cfg_wdata
);

  localparam int SW      = mmlr_pkg::SAMPLE_W;
  localparam int PHASE_W = FRAC_BITS + 4;
  localparam int SUM_W   = ((PHASE_W > mmlr_pkg::STEP_W) ? PHASE_W : mmlr_pkg::STEP_W) + 1;
  localparam int PROD_W  = FRAC_BITS + SW + 2;
  localparam int NUM_W   = FRAC_BITS + SW + 3;

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_BITS;
  localparam logic [PHASE_W-1:0] PHASE_TWO = PHASE_W'(2) << FRAC_BITS;
  localparam logic [PHASE_W-1:0] PHASE_MAX = {PHASE_W{1'b1}};
  localparam logic [NUM_W-1:0]   RND_BIAS  = (NUM_W'(1) << FRAC_BITS) - NUM_W'(1);

  mmlr_pkg::state_t state, state_next;

  logic [mmlr_pkg::STEP_W-1:0] step_ratio;
  logic                        stereo_mode;

  logic signed [SW-1:0]     in_first, in_second;
  logic                     in_begin;
  logic signed [SW-1:0]     older, newer;
  logic [PHASE_W-1:0]       phase;
  logic [mmlr_pkg::CNT_W-1:0] count;
  logic signed [PROD_W-1:0] prod;
  logic signed [SW-1:0]     out_sample;
  logic                     out_last;

  // mix and phase drop
  logic signed [SW:0]       mix_sum, mix_half;
  logic signed [SW-1:0]     mono;
  logic [PHASE_W-1:0]       phase_base, phase_drop;
  logic signed [SW-1:0]     newer_base;

  // interpolation and phase advance
  logic signed [SW:0]       diff;
  logic signed [FRAC_BITS:0] frac;
  logic signed [NUM_W-1:0]  num, num_adj;
  logic [SUM_W-1:0]         phase_sum;
  logic [PHASE_W-1:0]       phase_sat;
  logic                     last_now;

  always_comb begin
    mix_sum    = {in_first[SW-1], in_first} + {in_second[SW-1], in_second};
    // truncate toward zero: bias negatives by one before the shift
    mix_half   = (mix_sum + ((mix_sum[SW]) ? (SW+1)'(1) : (SW+1)'(0))) >>> 1;
    mono       = stereo_mode ? mix_half[SW-1:0] : in_first;
    phase_base = in_begin ? PHASE_TWO : phase;
    newer_base = in_begin ? '0 : newer;
    phase_drop = (phase_base >= PHASE_ONE) ? (phase_base - PHASE_ONE) : '0;

    diff = {newer[SW-1], newer} - {older[SW-1], older};
    frac = $signed({1'b0, phase[FRAC_BITS-1:0]});

    num     = ({{(NUM_W-SW){older[SW-1]}}, older} <<< FRAC_BITS)
              + {{(NUM_W-PROD_W){prod[PROD_W-1]}}, prod};
    num_adj = num + (num[NUM_W-1] ? $signed(RND_BIAS) : $signed(NUM_W'(0)));

    phase_sum = SUM_W'(phase) + SUM_W'(step_ratio);
    phase_sat = (phase_sum > SUM_W'(PHASE_MAX)) ? PHASE_MAX : phase_sum[PHASE_W-1:0];
    last_now  = (phase_sat >= PHASE_ONE) || (count == mmlr_pkg::CNT_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio  <= mmlr_pkg::STEP_RESET;
      stereo_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        mmlr_pkg::REG_STEP_RATIO:  step_ratio  <= cfg_wdata;
        mmlr_pkg::REG_STEREO_MODE: stereo_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmlr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    case (state)
      mmlr_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = mmlr_pkg::ST_MIX;
      end
      mmlr_pkg::ST_MIX: begin
        state_next = (phase_drop < PHASE_ONE) ? mmlr_pkg::ST_MUL : mmlr_pkg::ST_IDLE;
      end
      mmlr_pkg::ST_MUL: state_next = mmlr_pkg::ST_SUM;
      mmlr_pkg::ST_SUM: state_next = mmlr_pkg::ST_HOLD;
      mmlr_pkg::ST_HOLD: begin
        m_tvalid = 1'b1;
        if (m_tready) state_next = out_last ? mmlr_pkg::ST_IDLE : mmlr_pkg::ST_MUL;
      end
      default: state_next = mmlr_pkg::ST_IDLE;
    endcase
  end

  // input capture and datapath
  always_ff @(posedge clk) begin
    if (state == mmlr_pkg::ST_IDLE && s_tvalid) begin
      in_first  <= s_tdata[SW-1:0];
      in_second <= s_tdata[2*SW-1:SW];
      in_begin  <= s_tuser;
    end
    if (state == mmlr_pkg::ST_MUL) begin
      prod <= diff * frac;
    end
    if (state == mmlr_pkg::ST_SUM) begin
      out_sample <= num_adj[FRAC_BITS +: SW];
      out_last   <= last_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older <= '0;
      newer <= '0;
      phase <= PHASE_TWO;
      count <= '0;
    end else begin
      case (state)
        mmlr_pkg::ST_MIX: begin
          older <= newer_base;
          newer <= mono;
          phase <= phase_drop;
          count <= '0;
        end
        mmlr_pkg::ST_SUM: begin
          phase <= phase_sat;
          count <= count + mmlr_pkg::CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = out_sample;
  assign m_tlast = out_last;

endmodule

@@ rtl/mmlr_checker.sv @@
// Port-level checks for the resampler core, bound to the core module.
module mmlr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mmlr_pkg::SAMPLE_W-1:0] m_tdata,
  input logic                          m_tlast
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // never takes a frame while a result is pending
  a_busy_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while output word pending");

  // one frame at a time
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a frame was taken");

  // each result needs a fresh multiply, so no back-to-back output words
  a_out_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |=> !m_tvalid)
    else $error("output word right after a handshake");

endmodule

bind mono_mix_linear_resampler_core mmlr_checker u_mmlr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
